@@ hdl/ssd_pkg.sv @@
// shared types, constants and character decode for the seven-segment scan driver
`timescale 1ns / 1ps

package ssd_pkg;

  localparam int unsigned DIGITS = 4;

  localparam logic [7:0] DIGIT_ORDER_RESET = 8'd228;
  localparam logic [7:0] SEG_BLANK         = 8'hFF;

  localparam logic [2:0] OP_WRITE_CHAR = 3'd0;
  localparam logic [2:0] OP_CLEAR_POS  = 3'd1;
  localparam logic [2:0] OP_CLEAR_ALL  = 3'd2;
  localparam logic [2:0] OP_SET_AUX    = 3'd3;
  localparam logic [2:0] OP_SCAN_TICK  = 3'd4;

  // controller to datapath
  typedef struct packed {
    logic write_char;
    logic clear_pos;
    logic clear_all;
    logic set_aux;
    logic scan_tick;
  } ssd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic char_hit;
    logic slot_ok;
  } ssd_status_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] seg;
  } ssd_decode_t;

  // active-high glyphs, a = bit 0 to g = bit 6
  function automatic logic [6:0] ssd_glyph(input logic [3:0] idx);
    logic [6:0] g;
    case (idx)
      4'd0:    g = 7'h3F;
      4'd1:    g = 7'h06;
      4'd2:    g = 7'h5B;
      4'd3:    g = 7'h4F;
      4'd4:    g = 7'h66;
      4'd5:    g = 7'h6D;
      4'd6:    g = 7'h7D;
      4'd7:    g = 7'h07;
      4'd8:    g = 7'h7F;
      4'd9:    g = 7'h6F;
      4'd10:   g = 7'h77; // A
      4'd11:   g = 7'h73; // P
      4'd12:   g = 7'h31; // T
      4'd13:   g = 7'h30; // I
      4'd14:   g = 7'h37; // M
      4'd15:   g = 7'h79; // E
      default: g = 7'h00;
    endcase
    return g;
  endfunction

  // active-low segment byte, decimal point off
  function automatic ssd_decode_t ssd_decode(input logic [7:0] ch);
    ssd_decode_t r;
    logic [3:0]  idx;
    r.hit = 1'b1;
    r.seg = SEG_BLANK;
    idx   = 4'd0;
    case (ch) inside
      [8'h30:8'h3A]: idx = ch[3:0];
      8'h41, 8'h61:  idx = 4'd10;
      8'h50, 8'h70:  idx = 4'd11;
      8'h54, 8'h74:  idx = 4'd12;
      8'h49, 8'h69:  idx = 4'd13;
      8'h4D, 8'h6D:  idx = 4'd14;
      8'h45, 8'h65:  idx = 4'd15;
      8'h53, 8'h73:  idx = 4'd5;
      8'h00:         r.hit = 1'b1;
      default:       r.hit = 1'b0;
    endcase
    if (ch != 8'h00) begin
      r.seg = {1'b1, ~ssd_glyph(idx)};
    end
    return r;
  endfunction

endpackage

@@ hdl/ssd_ctrl.sv @@
// request handshake and output-slot state machine
`timescale 1ns / 1ps

module ssd_ctrl import ssd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic [2:0]  operation_i,
  input  logic        out_stall_i,
  input  ssd_status_t status_i,
  output logic        in_stall_o,
  output logic        out_valid_o,
  output ssd_cmd_t    cmd_o
);

  localparam logic ST_EMPTY = 1'b0;
  localparam logic ST_FULL  = 1'b1;

  logic state_q, state_d;
  logic accept;

  // a new request may be taken unless a held frame is stalled this cycle
  assign in_stall_o  = (state_q == ST_FULL) && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == ST_FULL);

  always_comb begin
    cmd_o = '0;
    if (accept) begin
      case (operation_i)
        OP_WRITE_CHAR: cmd_o.write_char = status_i.char_hit && status_i.slot_ok;
        OP_CLEAR_POS:  cmd_o.clear_pos  = status_i.slot_ok;
        OP_CLEAR_ALL:  cmd_o.clear_all  = 1'b1;
        OP_SET_AUX:    cmd_o.set_aux    = 1'b1;
        OP_SCAN_TICK:  cmd_o.scan_tick  = 1'b1;
        default:       cmd_o            = '0;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_EMPTY: begin
        if (cmd_o.scan_tick) state_d = ST_FULL;
      end
      ST_FULL: begin
        if (!cmd_o.scan_tick && !out_stall_i) state_d = ST_EMPTY;
      end
      default: state_d = ST_EMPTY;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_EMPTY;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hdl/ssd_datapath.sv @@
// digit buffer, digit-order register, scan counter and frame register
`timescale 1ns / 1ps

module ssd_datapath import ssd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_en_i,
  input  logic [7:0]  cfg_wr_data_i,
  input  logic [7:0]  character_i,
  input  logic [1:0]  position_i,
  input  logic [3:0]  aux_mask_i,
  input  ssd_cmd_t    cmd_i,
  output ssd_status_t status_o,
  output logic [7:0]  frame_first_o,
  output logic [7:0]  frame_second_o
);

  logic [7:0]  digit_order_q;
  logic [7:0]  digit_buffer_q [DIGITS];
  logic [3:0]  aux_bits_q;
  logic [1:0]  scan_position_q, scan_position_d;
  logic [7:0]  frame_first_q, frame_second_q;
  logic [1:0]  slot;
  ssd_decode_t dec;

  assign slot = digit_order_q[{position_i, 1'b0} +: 2];
  assign dec  = ssd_decode(character_i);

  assign status_o.char_hit = dec.hit;
  assign status_o.slot_ok  = ({1'b0, slot} < 3'(DIGITS));

  // wrap after the last fitted digit
  always_comb begin
    if ((3'({1'b0, scan_position_q}) + 3'd1) >= 3'(DIGITS)) begin
      scan_position_d = 2'd0;
    end else begin
      scan_position_d = scan_position_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_order_q   <= DIGIT_ORDER_RESET;
      aux_bits_q      <= '0;
      scan_position_q <= '0;
      for (int i = 0; i < DIGITS; i++) begin
        digit_buffer_q[i] <= '0;
      end
    end else begin
      if (cfg_wr_en_i) digit_order_q <= cfg_wr_data_i;
      if (cmd_i.set_aux) aux_bits_q <= aux_mask_i;
      if (cmd_i.scan_tick) scan_position_q <= scan_position_d;
      if (cmd_i.clear_all) begin
        for (int i = 0; i < DIGITS; i++) begin
          digit_buffer_q[i] <= SEG_BLANK;
        end
      end else if (cmd_i.write_char || cmd_i.clear_pos) begin
        digit_buffer_q[slot[$clog2(DIGITS > 1 ? DIGITS : 2)-1:0]] <=
          cmd_i.write_char ? dec.seg : SEG_BLANK;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_tick) begin
      frame_first_q  <= {aux_bits_q, 4'b0001 << scan_position_d};
      frame_second_q <= digit_buffer_q[scan_position_d[$clog2(DIGITS > 1 ? DIGITS : 2)-1:0]];
    end
  end

  assign frame_first_o  = frame_first_q;
  assign frame_second_o = frame_second_q;

endmodule

@@ hdl/seven_segment_scan_driver.sv @@
// top level of the four-digit multiplexed seven-segment scan driver
`timescale 1ns / 1ps

// Write char, clear position, clear all and set aux update the digit buffer or
// aux register at the accepting edge; a scan tick advances the scan position
// (first tick after reset scans digit 1) and loads a two-byte frame into the
// output register, valid the next cycle. Requests keep flowing while a frame
// waits; in_stall_o rises only when a frame is held and out_stall_i is high.
// Segments are active low, a on bit 0 to g on bit 6, decimal point on bit 7
// kept off. digit_order must be written only when idle, by the user; unchecked.
module seven_segment_scan_driver import ssd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_wr_en_i,
  input  logic [7:0] cfg_wr_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] operation_i,
  input  logic [7:0] character_i,
  input  logic [1:0] position_i,
  input  logic [3:0] aux_mask_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] frame_first_o,
  output logic [7:0] frame_second_o
);

  ssd_cmd_t    cmd;
  ssd_status_t status;

  ssd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .operation_i (operation_i),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  ssd_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_wr_en_i    (cfg_wr_en_i),
    .cfg_wr_data_i  (cfg_wr_data_i),
    .character_i    (character_i),
    .position_i     (position_i),
    .aux_mask_i     (aux_mask_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .frame_first_o  (frame_first_o),
    .frame_second_o (frame_second_o)
  );

endmodule

@@ test/tb_seven_segment_scan_driver.sv @@
// self-checking testbench for the seven-segment scan driver, with a frame scoreboard
`timescale 1ns / 1ps

module tb_seven_segment_scan_driver import ssd_pkg::*;;

  localparam logic [2:0] OP_UNUSED_LO    = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI    = 3'd7;
  localparam int         HOLD_OFF_CYCLES = 300;
  localparam int         DRAIN_LIMIT     = 5000;
  localparam int         PHASE_REQUESTS  = 250;

  typedef struct packed {
    logic [7:0] first;
    logic [7:0] second;
  } frame_t;

  // tracks the display memory and aux bits, and holds the frames still to come out
  class scan_display_tracker;
    logic [7:0] digit_order;
    logic [7:0] digit_buf [DIGITS];
    logic [3:0] aux_bits;
    logic [1:0] scan_pos;
    frame_t     frames_due [$];
    int         mismatch_count;

    function new();
      digit_order = DIGIT_ORDER_RESET;
      foreach (digit_buf[i]) digit_buf[i] = 8'h00;
      aux_bits       = 4'h0;
      scan_pos       = 2'd0;
      mismatch_count = 0;
    endfunction

    function int pending();
      return frames_due.size();
    endfunction

    task report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatch_count++;
    endtask

    // returns 0 when the character leaves the digit as it is
    function bit decode_char(input logic [7:0] ch, output logic [7:0] seg);
      logic [6:0] lit;
      seg = SEG_BLANK;
      if (ch == 8'h00) return 1'b1;
      case (ch)
        8'h30: lit = 7'h3F;
        8'h31: lit = 7'h06;
        8'h32: lit = 7'h5B;
        8'h33: lit = 7'h4F;
        8'h34: lit = 7'h66;
        8'h35, 8'h53, 8'h73: lit = 7'h6D;      // '5', 'S', 's'
        8'h36: lit = 7'h7D;
        8'h37: lit = 7'h07;
        8'h38: lit = 7'h7F;
        8'h39: lit = 7'h6F;
        8'h3A, 8'h41, 8'h61: lit = 7'h77;      // ':' shows 'A' as well
        8'h50, 8'h70: lit = 7'h73;
        8'h54, 8'h74: lit = 7'h31;
        8'h49, 8'h69: lit = 7'h30;
        8'h4D, 8'h6D: lit = 7'h37;
        8'h45, 8'h65: lit = 7'h79;
        default: return 1'b0;
      endcase
      seg = {1'b1, ~lit};
      return 1'b1;
    endfunction

    function void note_request(input logic [2:0] op, input logic [7:0] ch,
                               input logic [1:0] pos, input logic [3:0] aux);
      int         slot;
      logic [7:0] seg;
      frame_t     f;
      slot = int'(digit_order[{pos, 1'b0} +: 2]);
      case (op)
        OP_WRITE_CHAR: begin
          if (slot < DIGITS && decode_char(ch, seg)) digit_buf[slot] = seg;
        end
        OP_CLEAR_POS: begin
          if (slot < DIGITS) digit_buf[slot] = SEG_BLANK;
        end
        OP_CLEAR_ALL: begin
          foreach (digit_buf[i]) digit_buf[i] = SEG_BLANK;
        end
        OP_SET_AUX: begin
          aux_bits = aux;
        end
        OP_SCAN_TICK: begin
          if (int'(scan_pos) + 1 >= DIGITS) scan_pos = 2'd0;
          else scan_pos = scan_pos + 2'd1;
          f.first  = {aux_bits, 4'b0001 << scan_pos};
          f.second = digit_buf[scan_pos];
          frames_due.push_back(f);
        end
        default: ;
      endcase
    endfunction

    task check_frame(input logic [7:0] first, input logic [7:0] second);
      frame_t want;
      if (frames_due.size() == 0) begin
        report_mismatch($sformatf("frame %02h %02h with none due", first, second));
      end else begin
        want = frames_due.pop_front();
        if (first !== want.first)
          report_mismatch($sformatf("frame_first %02h, expected %02h", first, want.first));
        if (second !== want.second)
          report_mismatch($sformatf("frame_second %02h, expected %02h", second, want.second));
      end
    endtask
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_wr_en_i;
  logic [7:0] cfg_wr_data_i;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [2:0] operation_i;
  logic [7:0] character_i;
  logic [1:0] position_i;
  logic [3:0] aux_mask_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] frame_first_o;
  logic [7:0] frame_second_o;

  bit hold_off_req;

  scan_display_tracker tracker;

  seven_segment_scan_driver dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_wr_en_i    (cfg_wr_en_i),
    .cfg_wr_data_i  (cfg_wr_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .character_i    (character_i),
    .position_i     (position_i),
    .aux_mask_i     (aux_mask_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .frame_first_o  (frame_first_o),
    .frame_second_o (frame_second_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // frames are checked before the request of the same edge is noted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) tracker.check_frame(frame_first_o, frame_second_o);
      if (in_valid_i && !in_stall_o)
        tracker.note_request(operation_i, character_i, position_i, aux_mask_i);
    end
  end

  // receiver: runs of free flow, random, heavy and periodic stalls, plus one long hold-off
  initial begin : receiver
    int mode;
    int run_left;
    int hold_left;
    mode         = 0;
    run_left     = 0;
    hold_left    = 0;
    hold_off_req = 1'b0;
    out_stall_i <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_OFF_CYCLES;
      end
      if (run_left == 0) begin
        mode     = $urandom_range(0, 3);
        run_left = $urandom_range(8, 60);
      end
      run_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        case (mode)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(0, 1) == 1);
          2:       out_stall_i <= ($urandom_range(0, 3) != 0);
          default: out_stall_i <= (run_left % 3 == 0);
        endcase
      end
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(input logic [2:0] op, input logic [7:0] ch,
                              input logic [1:0] pos, input logic [3:0] aux);
    in_valid_i  <= 1'b1;
    operation_i <= op;
    character_i <= ch;
    position_i  <= pos;
    aux_mask_i  <= aux;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0 && guard < DRAIN_LIMIT) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_order(input logic [7:0] order);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= order;
    @(negedge clk_i);
    cfg_wr_en_i <= 1'b0;
    tracker.digit_order = order;
  endtask

  // bursts of random length with random gaps; ignored opcodes do not count
  task automatic run_random(input int count);
    int         burst;
    int         gap;
    int         pick;
    logic [2:0] op;
    logic [7:0] ch;
    while (count > 0) begin
      burst = $urandom_range(1, 20);
      while (burst > 0 && count > 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 35) op = OP_WRITE_CHAR;
        else if (pick < 43) op = OP_CLEAR_POS;
        else if (pick < 46) op = OP_CLEAR_ALL;
        else if (pick < 56) op = OP_SET_AUX;
        else if (pick < 96) op = OP_SCAN_TICK;
        else op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          ch = 8'h30 + 8'($urandom_range(0, 10));
        end else if (pick < 70) begin
          case ($urandom_range(0, 13))
            0:       ch = 8'h41;
            1:       ch = 8'h61;
            2:       ch = 8'h45;
            3:       ch = 8'h65;
            4:       ch = 8'h49;
            5:       ch = 8'h69;
            6:       ch = 8'h4D;
            7:       ch = 8'h6D;
            8:       ch = 8'h50;
            9:       ch = 8'h70;
            10:      ch = 8'h53;
            11:      ch = 8'h73;
            12:      ch = 8'h54;
            default: ch = 8'h74;
          endcase
        end else if (pick < 80) begin
          ch = 8'h00;
        end else begin
          ch = 8'($urandom);
        end
        send_request(op, ch, 2'($urandom), 4'($urandom));
        if (op <= OP_SCAN_TICK) count--;
        burst--;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
  endtask

  initial begin : stimulus
    logic [7:0] order;
    tracker = new();
    rst_ni        <= 1'b0;
    cfg_wr_en_i   <= 1'b0;
    cfg_wr_data_i <= 8'h00;
    in_valid_i    <= 1'b0;
    operation_i   <= OP_WRITE_CHAR;
    character_i   <= 8'h00;
    position_i    <= 2'd0;
    aux_mask_i    <= 4'h0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // digits, colon and letters of both cases, then one sweep over all positions
    send_request(OP_WRITE_CHAR, 8'h30, 2'd0, 4'h0);
    send_request(OP_WRITE_CHAR, 8'h3A, 2'd1, 4'h0);
    send_request(OP_WRITE_CHAR, 8'h61, 2'd2, 4'h0);
    send_request(OP_WRITE_CHAR, 8'h53, 2'd3, 4'h0);
    repeat (4) send_request(OP_SCAN_TICK, 8'h00, 2'd0, 4'h0);
    // unknown code keeps the digit, code zero blanks it
    send_request(OP_WRITE_CHAR, 8'hFF, 2'd0, 4'hF);
    send_request(OP_WRITE_CHAR, 8'h00, 2'd1, 4'h0);
    send_request(OP_WRITE_CHAR, 8'h6D, 2'd2, 4'h0);
    send_request(OP_WRITE_CHAR, 8'h39, 2'd3, 4'h0);
    send_request(OP_CLEAR_POS, 8'hFF, 2'd3, 4'h0);
    send_request(OP_SET_AUX, 8'h00, 2'd0, 4'hF);
    repeat (4) send_request(OP_SCAN_TICK, 8'hFF, 2'd3, 4'h0);
    send_request(OP_UNUSED_LO, 8'hFF, 2'd3, 4'hF);
    send_request(OP_UNUSED_HI, 8'h30, 2'd0, 4'h5);
    send_request(OP_CLEAR_ALL, 8'h45, 2'd2, 4'hA);
    send_request(OP_SET_AUX, 8'h00, 2'd0, 4'h0);
    send_request(OP_SCAN_TICK, 8'h00, 2'd0, 4'h0);
    send_request(OP_WRITE_CHAR, 8'h45, 2'd0, 4'hF);
    send_request(OP_SCAN_TICK, 8'h00, 2'd0, 4'h0);
    wait_drained();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       order = 8'h00;
        1:       order = 8'hFF;
        2:       order = 8'h1B;   // reversed order
        3:       order = DIGIT_ORDER_RESET;
        default: order = 8'($urandom);
      endcase
      write_order(order);
      // long receiver hold-off while requests keep coming
      if (phase == 2) hold_off_req = 1'b1;
      run_random(PHASE_REQUESTS);
      wait_drained();
    end

    if (tracker.pending() != 0)
      tracker.report_mismatch($sformatf("%0d frames never delivered", tracker.pending()));
    if (tracker.mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/ssd_pkg.sv
hdl/ssd_ctrl.sv
hdl/ssd_datapath.sv
hdl/seven_segment_scan_driver.sv
test/tb_seven_segment_scan_driver.sv
